/* design/tbes_pkg.sv */
// Shared types and constants for the two-body Euler step block.
`timescale 1ns / 1ps

package tbes_pkg;

    // Number of fraction bits in every fixed-point quantity.
    localparam int FRAC_BITS = 48;

    localparam logic [62:0] MAX63     = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN64    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXS64    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] UNIT_ONE  = 63'(1) << FRAC_BITS;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GM_FIRST  = 2'd0;
    localparam logic [1:0] CFG_GM_SECOND = 2'd1;
    localparam logic [1:0] CFG_STEP      = 2'd2;
    localparam logic [1:0] CFG_STOP      = 2'd3;

    // Configuration reset values.
    localparam logic [62:0] RST_GM   = 63'd110886;
    localparam logic [62:0] RST_STEP = 63'd281474976710656;
    localparam logic [62:0] RST_STOP = 63'd28147497671066;

    // Positions and velocities of both bodies.
    typedef struct packed {
        logic [63:0] x_first;
        logic [63:0] y_first;
        logic [63:0] x_second;
        logic [63:0] y_second;
        logic [63:0] vx_first;
        logic [63:0] vy_first;
        logic [63:0] vx_second;
        logic [63:0] vy_second;
    } state_t;

    // Micro-operations executed by the datapath.
    typedef enum logic [4:0] {
        U_MOVE_X1, U_MOVE_X2, U_MOVE_Y1, U_MOVE_Y2,
        U_DIFF, U_SQ_X, U_SQ_Y, U_SQRT,
        U_DIV_UX, U_DIV_UY, U_DIV_T1, U_DIV_G1, U_DIV_T2, U_DIV_G2,
        U_MUL_A1X, U_MUL_D1X, U_MUL_A2X, U_MUL_D2X,
        U_MUL_A1Y, U_MUL_D1Y, U_MUL_A2Y, U_MUL_D2Y
    } uop_t;

    // Controller states.
    typedef enum logic [1:0] {
        C_IDLE, C_ISSUE, C_WAIT, C_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        uop_t uop;
        logic load;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic big;
        logic r_zero;
    } status_t;

endpackage

/* design/tbes_mul.sv */
// Shared 64 by 64 unsigned multiplier built from four 32 by 32 partial products.
`timescale 1ns / 1ps

module tbes_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         busy,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg, b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, pp_valid_reg, done_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   idx_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half, b_half;
    logic [127:0] pp_shifted;

    // Select the halves for the current partial product.
    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    // Align the registered partial product.
    always_comb begin
        unique case (idx_reg)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {32'b0, pp_reg, 32'b0};
            default: pp_shifted = {pp_reg, 64'b0};
        endcase
    end

    // Control sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= 3'd0;
        end else if (start) begin
            busy_reg     <= 1'b1;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= 3'd0;
        end else begin
            pp_valid_reg <= busy_reg && !cnt_reg[2];
            done_reg     <= busy_reg && cnt_reg[2];
            if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg[2]) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Operands, partial products and accumulation.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else begin
            pp_reg  <= a_half * b_half;
            idx_reg <= cnt_reg[1:0];
            if (pp_valid_reg) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* design/tbes_divsqrt.sv */
// Shared bit-serial unit for saturating division and integer square root.
`timescale 1ns / 1ps

module tbes_divsqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        op_sqrt,
    input  logic [63:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output logic        busy,
    output logic        done,
    output logic [62:0] result
);

    logic [66:0]  rem_reg, shin, sub, rem_next;
    logic [63:0]  root_reg, den_reg;
    logic [127:0] src_reg;
    logic         sqrt_reg, sat_reg, busy_reg, done_reg, ge;
    logic [5:0]   cnt_reg;

    // One restoring step: shift in source bits, trial subtract.
    always_comb begin
        if (sqrt_reg) begin
            shin = {rem_reg[64:0], src_reg[127:126]};
            sub  = {1'b0, root_reg, 2'b01};
        end else begin
            shin = {rem_reg[65:0], src_reg[127]};
            sub  = {3'b0, den_reg};
        end
        ge       = (shin >= sub);
        rem_next = ge ? (shin - sub) : shin;
    end

    // Control sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else if (start) begin
            busy_reg <= op_sqrt || (num_hi < den);
            done_reg <= !op_sqrt && (num_hi >= den);
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            sqrt_reg <= op_sqrt;
            sat_reg  <= !op_sqrt && (num_hi >= den);
            den_reg  <= den;
            root_reg <= '0;
            if (op_sqrt) begin
                rem_reg <= '0;
                src_reg <= {num_hi, num_lo};
            end else begin
                rem_reg <= {3'b0, num_hi};
                src_reg <= {num_lo, 64'b0};
            end
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            root_reg <= {root_reg[62:0], ge};
            src_reg  <= sqrt_reg ? (src_reg << 2) : (src_reg << 1);
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = (sat_reg || root_reg[63]) ? tbes_pkg::MAX63 : root_reg[62:0];

endmodule

/* design/tbes_datapath.sv */
// Datapath: body state, configuration, shared arithmetic units and result word.
`timescale 1ns / 1ps

module tbes_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  tbes_pkg::cmd_t    cmd,
    output tbes_pkg::status_t sts,
    input  tbes_pkg::state_t  load,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [62:0]       cfg_wdata,
    output tbes_pkg::state_t  out_state,
    output logic [62:0]       out_separation,
    output logic              out_closed
);

    localparam int F = tbes_pkg::FRAC_BITS;

    tbes_pkg::state_t st_reg, out_state_reg;
    tbes_pkg::uop_t   cur_uop_reg;
    logic [62:0]  gm1_reg, gm2_reg, step_reg, stop_reg;
    logic [63:0]  mx_reg, my_reg;
    logic         nx_reg, ny_reg, big_reg, done_reg;
    logic [62:0]  r_reg, ux_reg, uy_reg, g1_reg, g2_reg, tmp_reg;
    logic [127:0] sum_reg;
    logic [62:0]  out_sep_reg;
    logic         out_closed_reg;

    logic [63:0]  mul_a, mul_b, div_v, dx_c, dy_c;
    logic         mul_start, ds_start, mul_busy, ds_busy, mul_done, ds_done;
    logic         nx_c, ny_c, is_mul, is_div;
    logic [127:0] prod;
    logic [62:0]  ds_result, prod_sat;
    logic [63:0]  prod_dv;

    // Magnitude of a two's complement word.
    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Product shifted down, saturated as a magnitude.
    function automatic logic [62:0] mul_sat(input logic [127:0] p);
        logic [63:0] r;
        r = p[F+63:F];
        if ((|p[127:F+64]) || r[63]) return tbes_pkg::MAX63;
        return r[62:0];
    endfunction

    // Product shifted down with sign, saturated to the signed range.
    function automatic logic [63:0] mul_sgn(input logic [127:0] p, input logic neg);
        logic [63:0] r;
        r = p[F+63:F];
        if (|p[127:F+64]) return neg ? tbes_pkg::SIGN64 : tbes_pkg::MAXS64;
        if (neg) return (r > tbes_pkg::SIGN64) ? tbes_pkg::SIGN64 : (64'd0 - r);
        return r[63] ? tbes_pkg::MAXS64 : r;
    endfunction

    // Saturating signed add.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? tbes_pkg::SIGN64 : tbes_pkg::MAXS64;
        end
        return s;
    endfunction

    // Operand selection for the unit that the new micro-op starts.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        div_v  = '0;
        is_mul = 1'b0;
        is_div = 1'b0;
        unique case (cmd.uop)
            tbes_pkg::U_MOVE_X1: begin
                is_mul = 1'b1; mul_a = {1'b0, step_reg}; mul_b = abs64(st_reg.vx_first);
            end
            tbes_pkg::U_MOVE_X2: begin
                is_mul = 1'b1; mul_a = {1'b0, step_reg}; mul_b = abs64(st_reg.vx_second);
            end
            tbes_pkg::U_MOVE_Y1: begin
                is_mul = 1'b1; mul_a = {1'b0, step_reg}; mul_b = abs64(st_reg.vy_first);
            end
            tbes_pkg::U_MOVE_Y2: begin
                is_mul = 1'b1; mul_a = {1'b0, step_reg}; mul_b = abs64(st_reg.vy_second);
            end
            tbes_pkg::U_SQ_X: begin
                is_mul = 1'b1; mul_a = mx_reg; mul_b = mx_reg;
            end
            tbes_pkg::U_SQ_Y: begin
                is_mul = 1'b1; mul_a = my_reg; mul_b = my_reg;
            end
            tbes_pkg::U_MUL_A1X: begin
                is_mul = 1'b1; mul_a = {1'b0, g1_reg}; mul_b = {1'b0, ux_reg};
            end
            tbes_pkg::U_MUL_A2X: begin
                is_mul = 1'b1; mul_a = {1'b0, g2_reg}; mul_b = {1'b0, ux_reg};
            end
            tbes_pkg::U_MUL_A1Y: begin
                is_mul = 1'b1; mul_a = {1'b0, g1_reg}; mul_b = {1'b0, uy_reg};
            end
            tbes_pkg::U_MUL_A2Y: begin
                is_mul = 1'b1; mul_a = {1'b0, g2_reg}; mul_b = {1'b0, uy_reg};
            end
            tbes_pkg::U_MUL_D1X, tbes_pkg::U_MUL_D2X,
            tbes_pkg::U_MUL_D1Y, tbes_pkg::U_MUL_D2Y: begin
                is_mul = 1'b1; mul_a = {1'b0, step_reg}; mul_b = {1'b0, tmp_reg};
            end
            tbes_pkg::U_SQRT:   is_div = 1'b1;
            tbes_pkg::U_DIV_UX: begin is_div = 1'b1; div_v = mx_reg; end
            tbes_pkg::U_DIV_UY: begin is_div = 1'b1; div_v = my_reg; end
            tbes_pkg::U_DIV_T1: begin is_div = 1'b1; div_v = {1'b0, gm2_reg}; end
            tbes_pkg::U_DIV_T2: begin is_div = 1'b1; div_v = {1'b0, gm1_reg}; end
            tbes_pkg::U_DIV_G1, tbes_pkg::U_DIV_G2: begin
                is_div = 1'b1; div_v = {1'b0, tmp_reg};
            end
            default: ;
        endcase
    end

    assign mul_start = cmd.start && is_mul;
    assign ds_start  = cmd.start && is_div;

    tbes_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (prod)
    );

    tbes_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ds_start),
        .op_sqrt (cmd.uop == tbes_pkg::U_SQRT),
        .num_hi  ((cmd.uop == tbes_pkg::U_SQRT) ? sum_reg[127:64] : (div_v >> (64 - F))),
        .num_lo  ((cmd.uop == tbes_pkg::U_SQRT) ? sum_reg[63:0] : (div_v << F)),
        .den     ({1'b0, r_reg}),
        .busy    (ds_busy),
        .done    (ds_done),
        .result  (ds_result)
    );

    // Separation components from the current positions.
    always_comb begin
        nx_c = $signed(st_reg.x_first) < $signed(st_reg.x_second);
        ny_c = $signed(st_reg.y_first) < $signed(st_reg.y_second);
        dx_c = nx_c ? (st_reg.x_second - st_reg.x_first) : (st_reg.x_first - st_reg.x_second);
        dy_c = ny_c ? (st_reg.y_second - st_reg.y_first) : (st_reg.y_first - st_reg.y_second);
    end

    assign prod_sat = mul_sat(prod);
    assign prod_dv  = {1'b0, prod_sat};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gm1_reg  <= tbes_pkg::RST_GM;
            gm2_reg  <= tbes_pkg::RST_GM;
            step_reg <= tbes_pkg::RST_STEP;
            stop_reg <= tbes_pkg::RST_STOP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tbes_pkg::CFG_GM_FIRST:  gm1_reg  <= cfg_wdata;
                tbes_pkg::CFG_GM_SECOND: gm2_reg  <= cfg_wdata;
                tbes_pkg::CFG_STEP:      step_reg <= cfg_wdata;
                tbes_pkg::CFG_STOP:      stop_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Body state: loads and the write-back of position and velocity updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (cmd.load) begin
            st_reg <= load;
        end else if (mul_done) begin
            unique case (cur_uop_reg)
                tbes_pkg::U_MOVE_X1: st_reg.x_first <=
                    sat_add(st_reg.x_first, mul_sgn(prod, st_reg.vx_first[63]));
                tbes_pkg::U_MOVE_X2: st_reg.x_second <=
                    sat_add(st_reg.x_second, mul_sgn(prod, st_reg.vx_second[63]));
                tbes_pkg::U_MOVE_Y1: st_reg.y_first <=
                    sat_add(st_reg.y_first, mul_sgn(prod, st_reg.vy_first[63]));
                tbes_pkg::U_MOVE_Y2: st_reg.y_second <=
                    sat_add(st_reg.y_second, mul_sgn(prod, st_reg.vy_second[63]));
                tbes_pkg::U_MUL_D1X: st_reg.vx_first <=
                    sat_add(st_reg.vx_first, nx_reg ? prod_dv : (64'd0 - prod_dv));
                tbes_pkg::U_MUL_D2X: st_reg.vx_second <=
                    sat_add(st_reg.vx_second, nx_reg ? (64'd0 - prod_dv) : prod_dv);
                tbes_pkg::U_MUL_D1Y: st_reg.vy_first <=
                    sat_add(st_reg.vy_first, ny_reg ? prod_dv : (64'd0 - prod_dv));
                tbes_pkg::U_MUL_D2Y: st_reg.vy_second <=
                    sat_add(st_reg.vy_second, ny_reg ? (64'd0 - prod_dv) : prod_dv);
                default: ;
            endcase
        end
    end

    // Intermediate values of one step.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_uop_reg <= cmd.uop;
        end
        if (cmd.start && (cmd.uop == tbes_pkg::U_DIFF)) begin
            mx_reg  <= dx_c;
            my_reg  <= dy_c;
            nx_reg  <= nx_c;
            ny_reg  <= ny_c;
            big_reg <= dx_c[63] || dy_c[63];
            if (dx_c[63] || dy_c[63]) begin
                r_reg <= tbes_pkg::MAX63;
            end
        end
        if (mul_done) begin
            unique case (cur_uop_reg)
                tbes_pkg::U_SQ_X: sum_reg <= prod;
                tbes_pkg::U_SQ_Y: sum_reg <= sum_reg + prod;
                tbes_pkg::U_MUL_A1X, tbes_pkg::U_MUL_A2X,
                tbes_pkg::U_MUL_A1Y, tbes_pkg::U_MUL_A2Y: tmp_reg <= prod_sat;
                default: ;
            endcase
        end
        if (ds_done) begin
            unique case (cur_uop_reg)
                tbes_pkg::U_SQRT:   r_reg <= ds_result;
                tbes_pkg::U_DIV_UX: ux_reg <= (ds_result > tbes_pkg::UNIT_ONE) ?
                                              tbes_pkg::UNIT_ONE : ds_result;
                tbes_pkg::U_DIV_UY: uy_reg <= (ds_result > tbes_pkg::UNIT_ONE) ?
                                              tbes_pkg::UNIT_ONE : ds_result;
                tbes_pkg::U_DIV_T1, tbes_pkg::U_DIV_T2: tmp_reg <= ds_result;
                tbes_pkg::U_DIV_G1: g1_reg <= ds_result;
                tbes_pkg::U_DIV_G2: g2_reg <= ds_result;
                default: ;
            endcase
        end
    end

    // Completion flag for the running micro-op.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= mul_done || ds_done ||
                        (cmd.start && (cmd.uop == tbes_pkg::U_DIFF));
        end
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_state_reg  <= st_reg;
            out_sep_reg    <= r_reg;
            out_closed_reg <= (r_reg <= stop_reg);
        end
    end

    assign sts.done       = done_reg;
    assign sts.big        = big_reg;
    assign sts.r_zero     = (r_reg == '0);
    assign out_state      = out_state_reg;
    assign out_separation = out_sep_reg;
    assign out_closed     = out_closed_reg;

    // A new micro-op only starts when both arithmetic units are free.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (!mul_busy && !ds_busy))
        else $error("micro-op started while an arithmetic unit is busy");

    // Only one unit finishes at a time.
    a_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_done && ds_done))
        else $error("both arithmetic units finished together");

endmodule

/* design/tbes_ctrl.sv */
// Controller: accepts words, sequences micro-ops and hands off result words.
`timescale 1ns / 1ps

module tbes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    output logic              m_valid,
    input  logic              m_ready,
    output tbes_pkg::cmd_t    cmd,
    input  tbes_pkg::status_t sts
);

    tbes_pkg::ctrl_state_t state_reg, state_next;
    tbes_pkg::uop_t        uop_reg, uop_next, uop_after;
    logic                  mode_reg, mode_next, m_valid_reg, m_valid_next, last;

    // Micro-op that follows the current one; last marks the end of an item.
    always_comb begin
        uop_after = uop_reg;
        last      = 1'b0;
        unique case (uop_reg)
            tbes_pkg::U_MOVE_X1: uop_after = tbes_pkg::U_MOVE_X2;
            tbes_pkg::U_MOVE_X2: uop_after = tbes_pkg::U_MOVE_Y1;
            tbes_pkg::U_MOVE_Y1: uop_after = tbes_pkg::U_MOVE_Y2;
            tbes_pkg::U_MOVE_Y2: uop_after = tbes_pkg::U_DIFF;
            tbes_pkg::U_DIFF: begin
                // A huge separation skips the square root.
                if (!sts.big) begin
                    uop_after = tbes_pkg::U_SQ_X;
                end else if (mode_reg) begin
                    uop_after = tbes_pkg::U_DIV_UX;
                end else begin
                    last = 1'b1;
                end
            end
            tbes_pkg::U_SQ_X: uop_after = tbes_pkg::U_SQ_Y;
            tbes_pkg::U_SQ_Y: uop_after = tbes_pkg::U_SQRT;
            tbes_pkg::U_SQRT: begin
                if (mode_reg && !sts.r_zero) begin
                    uop_after = tbes_pkg::U_DIV_UX;
                end else begin
                    last = 1'b1;
                end
            end
            tbes_pkg::U_DIV_UX:  uop_after = tbes_pkg::U_DIV_UY;
            tbes_pkg::U_DIV_UY:  uop_after = tbes_pkg::U_DIV_T1;
            tbes_pkg::U_DIV_T1:  uop_after = tbes_pkg::U_DIV_G1;
            tbes_pkg::U_DIV_G1:  uop_after = tbes_pkg::U_DIV_T2;
            tbes_pkg::U_DIV_T2:  uop_after = tbes_pkg::U_DIV_G2;
            tbes_pkg::U_DIV_G2:  uop_after = tbes_pkg::U_MUL_A1X;
            tbes_pkg::U_MUL_A1X: uop_after = tbes_pkg::U_MUL_D1X;
            tbes_pkg::U_MUL_D1X: uop_after = tbes_pkg::U_MUL_A2X;
            tbes_pkg::U_MUL_A2X: uop_after = tbes_pkg::U_MUL_D2X;
            tbes_pkg::U_MUL_D2X: uop_after = tbes_pkg::U_MUL_A1Y;
            tbes_pkg::U_MUL_A1Y: uop_after = tbes_pkg::U_MUL_D1Y;
            tbes_pkg::U_MUL_D1Y: uop_after = tbes_pkg::U_MUL_A2Y;
            tbes_pkg::U_MUL_A2Y: uop_after = tbes_pkg::U_MUL_D2Y;
            tbes_pkg::U_MUL_D2Y: last = 1'b1;
            default: last = 1'b1;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        uop_next   = uop_reg;
        mode_next  = mode_reg;
        unique case (state_reg)
            tbes_pkg::C_IDLE: begin
                if (s_valid) begin
                    state_next = tbes_pkg::C_ISSUE;
                    mode_next  = s_mode;
                    uop_next   = s_mode ? tbes_pkg::U_MOVE_X1 : tbes_pkg::U_DIFF;
                end
            end
            tbes_pkg::C_ISSUE: state_next = tbes_pkg::C_WAIT;
            tbes_pkg::C_WAIT: begin
                if (sts.done) begin
                    if (last) begin
                        state_next = tbes_pkg::C_OUT;
                    end else begin
                        state_next = tbes_pkg::C_ISSUE;
                        uop_next   = uop_after;
                    end
                end
            end
            tbes_pkg::C_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tbes_pkg::C_IDLE;
                end
            end
            default: state_next = tbes_pkg::C_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        s_ready      = 1'b0;
        cmd.start    = 1'b0;
        cmd.uop      = uop_reg;
        cmd.load     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            tbes_pkg::C_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid && !s_mode;
            end
            tbes_pkg::C_ISSUE: cmd.start = 1'b1;
            tbes_pkg::C_WAIT:  ;
            tbes_pkg::C_OUT:   cmd.out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tbes_pkg::C_IDLE;
            uop_reg     <= tbes_pkg::U_DIFF;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            uop_reg     <= uop_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // A result word is never written over one still waiting to be taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten before it was taken");

    // Completion is only reported while a micro-op is in flight.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> (state_reg == tbes_pkg::C_WAIT))
        else $error("datapath done outside of a wait");

endmodule

/* design/two_body_euler_step.sv */
// Top level of the two-body explicit Euler step engine.
//
//   channel   | direction | handshake          | payload
//   s_*       | in        | s_valid / s_ready  | mode and eight load values
//   m_*       | out       | m_valid / m_ready  | state, separation, closed
//   cfg_*     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// One word is processed at a time. Its processing time is set by the bit-serial
// divide and square root unit (up to six divides and one root per step word)
// plus each pass through the shared multiplier. Reset is synchronous and
// active low; it restores the configuration defaults and zeroes both bodies.
// A waiting result word does not block acceptance of the next input word.
`timescale 1ns / 1ps

module two_body_euler_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [63:0] s_load_x_first,
    input  logic [63:0] s_load_y_first,
    input  logic [63:0] s_load_x_second,
    input  logic [63:0] s_load_y_second,
    input  logic [63:0] s_load_vx_first,
    input  logic [63:0] s_load_vy_first,
    input  logic [63:0] s_load_vx_second,
    input  logic [63:0] s_load_vy_second,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_x_first,
    output logic [63:0] m_y_first,
    output logic [63:0] m_x_second,
    output logic [63:0] m_y_second,
    output logic [63:0] m_vx_first,
    output logic [63:0] m_vy_first,
    output logic [63:0] m_vx_second,
    output logic [63:0] m_vy_second,
    output logic [62:0] m_separation,
    output logic        m_closed,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_wdata
);

    tbes_pkg::cmd_t    cmd;
    tbes_pkg::status_t sts;
    tbes_pkg::state_t  load, out_state;

    // Gather the load values.
    assign load.x_first   = s_load_x_first;
    assign load.y_first   = s_load_y_first;
    assign load.x_second  = s_load_x_second;
    assign load.y_second  = s_load_y_second;
    assign load.vx_first  = s_load_vx_first;
    assign load.vy_first  = s_load_vy_first;
    assign load.vx_second = s_load_vx_second;
    assign load.vy_second = s_load_vy_second;

    tbes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    tbes_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .load           (load),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .out_state      (out_state),
        .out_separation (m_separation),
        .out_closed     (m_closed)
    );

    // Spread the result word onto its ports.
    assign m_x_first   = out_state.x_first;
    assign m_y_first   = out_state.y_first;
    assign m_x_second  = out_state.x_second;
    assign m_y_second  = out_state.y_second;
    assign m_vx_first  = out_state.vx_first;
    assign m_vy_first  = out_state.vy_first;
    assign m_vx_second = out_state.vx_second;
    assign m_vy_second = out_state.vy_second;

endmodule

/* dv/tb_two_body_euler_step.sv */
// Self-checking testbench for the two-body explicit Euler step engine.
`timescale 1ns / 1ps

module tb_two_body_euler_step;

    localparam int MAX_IDLE_CYCLES = 100000;
    localparam logic [63:0] UNIT64 = 64'(1) << tbes_pkg::FRAC_BITS;

    // One input word as the driver presents it.
    typedef struct packed {
        logic              mode;
        tbes_pkg::state_t  load;
    } body_word_t;

    // One result word.
    typedef struct packed {
        tbes_pkg::state_t  bodies;
        logic [62:0]       separation;
        logic              closed;
    } orbit_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [63:0] s_load_x_first, s_load_y_first, s_load_x_second, s_load_y_second;
    logic [63:0] s_load_vx_first, s_load_vy_first, s_load_vx_second, s_load_vy_second;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_x_first, m_y_first, m_x_second, m_y_second;
    logic [63:0] m_vx_first, m_vy_first, m_vx_second, m_vy_second;
    logic [62:0] m_separation;
    logic        m_closed;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [62:0] cfg_wdata;

    two_body_euler_step dut (.*);

    // Predictor copy of configuration and body state.
    logic [62:0]      gm_first_q, gm_second_q, step_q, stop_q;
    tbes_pkg::state_t bodies_q;

    body_word_t  pending_words[$];
    orbit_word_t expected_orbits[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          idle_cycles;
    bit          failed;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Scaled product of two magnitudes, (a*b) >> F, untruncated.
    function automatic logic [127:0] scaled_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p >> tbes_pkg::FRAC_BITS;
    endfunction

    function automatic logic [63:0] mul_mag_sat(logic [63:0] a, logic [63:0] b);
        logic [127:0] r;
        r = scaled_mul(a, b);
        return (r > 128'(tbes_pkg::MAXS64)) ? tbes_pkg::MAXS64 : r[63:0];
    endfunction

    function automatic logic [63:0] mul_signed_sat(logic [63:0] a, logic [63:0] b, bit neg);
        logic [127:0] r;
        r = scaled_mul(a, b);
        if (neg)
            return (r > 128'(tbes_pkg::SIGN64)) ? tbes_pkg::SIGN64 : 64'(0) - r[63:0];
        return (r > 128'(tbes_pkg::MAXS64)) ? tbes_pkg::MAXS64 : r[63:0];
    endfunction

    // v * 2^F / d with the quotient saturated to 2^63-1.
    function automatic logic [63:0] frac_div(logic [63:0] v, logic [63:0] d);
        logic [127:0] q;
        q = (128'(v) << tbes_pkg::FRAC_BITS) / 128'(d);
        return (q > 128'(tbes_pkg::MAXS64)) ? tbes_pkg::MAXS64 : q[63:0];
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? tbes_pkg::SIGN64 : tbes_pkg::MAXS64;
        return s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [127:0] n);
        logic [63:0] res;
        logic [63:0] t;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            t = res | (64'(1) << b);
            if (128'(t) * 128'(t) <= n)
                res = t;
        end
        return res;
    endfunction

    function automatic logic [63:0] advance_pos(logic [63:0] pos, logic [63:0] vel);
        logic [63:0] mag;
        mag = vel[63] ? 64'(0) - vel : vel;
        return add_sat(pos, mul_signed_sat({1'b0, step_q}, mag, vel[63]));
    endfunction

    function automatic logic [63:0] kick(logic [62:0] gm, logic [63:0] dmag, logic [63:0] r);
        logic [63:0] u, g;
        u = frac_div(dmag, r);
        g = frac_div(frac_div({1'b0, gm}, r), r);
        if (u > UNIT64)
            u = UNIT64;
        return mul_mag_sat({1'b0, step_q}, mul_mag_sat(g, u));
    endfunction

    // Apply one word to the predictor and return the expected result.
    function automatic orbit_word_t predict_orbit(body_word_t w);
        orbit_word_t o;
        logic [63:0] mx, my, r, d;
        bit          nx, ny;
        if (!w.mode) begin
            bodies_q = w.load;
        end else begin
            bodies_q.x_first  = advance_pos(bodies_q.x_first, bodies_q.vx_first);
            bodies_q.x_second = advance_pos(bodies_q.x_second, bodies_q.vx_second);
            bodies_q.y_first  = advance_pos(bodies_q.y_first, bodies_q.vy_first);
            bodies_q.y_second = advance_pos(bodies_q.y_second, bodies_q.vy_second);
        end
        nx = $signed(bodies_q.x_first) < $signed(bodies_q.x_second);
        ny = $signed(bodies_q.y_first) < $signed(bodies_q.y_second);
        mx = nx ? bodies_q.x_second - bodies_q.x_first : bodies_q.x_first - bodies_q.x_second;
        my = ny ? bodies_q.y_second - bodies_q.y_first : bodies_q.y_first - bodies_q.y_second;
        if (mx[63] || my[63])
            r = tbes_pkg::MAXS64;
        else
            r = int_sqrt(128'(mx) * 128'(mx) + 128'(my) * 128'(my));
        // The root of a sum of two large squares can pass the 63-bit range.
        if (r > tbes_pkg::MAXS64)
            r = tbes_pkg::MAXS64;
        if (w.mode && r != 0) begin
            d = kick(gm_second_q, mx, r);
            bodies_q.vx_first = add_sat(bodies_q.vx_first, nx ? d : 64'(0) - d);
            d = kick(gm_first_q, mx, r);
            bodies_q.vx_second = add_sat(bodies_q.vx_second, nx ? 64'(0) - d : d);
            d = kick(gm_second_q, my, r);
            bodies_q.vy_first = add_sat(bodies_q.vy_first, ny ? d : 64'(0) - d);
            d = kick(gm_first_q, my, r);
            bodies_q.vy_second = add_sat(bodies_q.vy_second, ny ? 64'(0) - d : d);
        end
        o.bodies     = bodies_q;
        o.separation = r[62:0];
        o.closed     = (r <= 64'(stop_q));
        return o;
    endfunction

    // Driver: presents pending words, predicting each one at acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_orbits.push_back(predict_orbit(
                    {s_mode, s_load_x_first, s_load_y_first, s_load_x_second,
                     s_load_y_second, s_load_vx_first, s_load_vy_first,
                     s_load_vx_second, s_load_vy_second}));
                void'(pending_words.pop_front());
            end
            if ((!s_valid || s_ready) && pending_words.size() > 0 &&
                ($urandom_range(99) >= send_idle_pct)) begin
                s_valid <= 1'b1;
                {s_mode, s_load_x_first, s_load_y_first, s_load_x_second, s_load_y_second,
                 s_load_vx_first, s_load_vy_first, s_load_vx_second, s_load_vy_second}
                    <= pending_words[0];
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge aclk) begin
        orbit_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_orbits.size() == 0) begin
                $error("unexpected result word");
                failed = 1'b1;
            end else begin
                e = expected_orbits.pop_front();
                if (m_x_first !== e.bodies.x_first) begin
                    $error("x_first exp %h got %h", e.bodies.x_first, m_x_first); failed = 1'b1;
                end
                if (m_y_first !== e.bodies.y_first) begin
                    $error("y_first exp %h got %h", e.bodies.y_first, m_y_first); failed = 1'b1;
                end
                if (m_x_second !== e.bodies.x_second) begin
                    $error("x_second exp %h got %h", e.bodies.x_second, m_x_second); failed = 1'b1;
                end
                if (m_y_second !== e.bodies.y_second) begin
                    $error("y_second exp %h got %h", e.bodies.y_second, m_y_second); failed = 1'b1;
                end
                if (m_vx_first !== e.bodies.vx_first) begin
                    $error("vx_first exp %h got %h", e.bodies.vx_first, m_vx_first); failed = 1'b1;
                end
                if (m_vy_first !== e.bodies.vy_first) begin
                    $error("vy_first exp %h got %h", e.bodies.vy_first, m_vy_first); failed = 1'b1;
                end
                if (m_vx_second !== e.bodies.vx_second) begin
                    $error("vx_second exp %h got %h", e.bodies.vx_second, m_vx_second);
                    failed = 1'b1;
                end
                if (m_vy_second !== e.bodies.vy_second) begin
                    $error("vy_second exp %h got %h", e.bodies.vy_second, m_vy_second);
                    failed = 1'b1;
                end
                if (m_separation !== e.separation) begin
                    $error("separation exp %h got %h", e.separation, m_separation); failed = 1'b1;
                end
                if (m_closed !== e.closed) begin
                    $error("closed exp %b got %b", e.closed, m_closed); failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= MAX_IDLE_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random 64-bit value, biased toward small magnitudes and extremes.
    function automatic logic [63:0] rand_coord(int shift);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? tbes_pkg::MAXS64 : tbes_pkg::SIGN64;
            1:       return v;
            default: return $signed(v) >>> shift;
        endcase
    endfunction

    function automatic body_word_t make_load(int shift);
        body_word_t w;
        w.mode = 1'b0;
        w.load = {rand_coord(shift), rand_coord(shift), rand_coord(shift), rand_coord(shift),
                  rand_coord(shift + 4), rand_coord(shift + 4),
                  rand_coord(shift + 4), rand_coord(shift + 4)};
        return w;
    endfunction

    function automatic body_word_t make_step();
        body_word_t w;
        w = make_load(0);
        w.mode = 1'b1;
        return w;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [62:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            tbes_pkg::CFG_GM_FIRST:  gm_first_q  = val;
            tbes_pkg::CFG_GM_SECOND: gm_second_q = val;
            tbes_pkg::CFG_STEP:      step_q      = val;
            tbes_pkg::CFG_STOP:      stop_q      = val;
        endcase
    endtask

    // Wait for all predicted words to drain, then let the engine settle.
    task automatic drain();
        while (pending_words.size() > 0 || expected_orbits.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    initial begin
        body_word_t w;
        failed = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = 1'b0;
        {s_load_x_first, s_load_y_first, s_load_x_second, s_load_y_second} = '0;
        {s_load_vx_first, s_load_vy_first, s_load_vx_second, s_load_vy_second} = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = tbes_pkg::CFG_GM_FIRST;
        cfg_wdata = '0;
        gm_first_q = tbes_pkg::RST_GM;
        gm_second_q = tbes_pkg::RST_GM;
        step_q = tbes_pkg::RST_STEP;
        stop_q = tbes_pkg::RST_STOP;
        bodies_q = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: step from reset (zero separation), extremes, huge separation.
        w = '0; w.mode = 1'b1; pending_words.push_back(w);
        w = '0; w.load.x_first = UNIT64; w.load.vy_first = UNIT64 >> 4;
        pending_words.push_back(w);
        w.mode = 1'b1; pending_words.push_back(w); pending_words.push_back(w);
        w = '0; w.load.x_first = tbes_pkg::MAXS64; w.load.x_second = tbes_pkg::SIGN64;
        w.load.vx_first = tbes_pkg::MAXS64; w.load.vx_second = tbes_pkg::SIGN64;
        pending_words.push_back(w);
        w.mode = 1'b1; pending_words.push_back(w);
        w = '0; w.load.y_first = tbes_pkg::SIGN64; w.load.y_second = 64'd1;
        w.load.vy_first = tbes_pkg::SIGN64; w.load.vy_second = tbes_pkg::MAXS64;
        pending_words.push_back(w);
        w.mode = 1'b1; pending_words.push_back(w);
        w = '0; w.load.x_first = 64'd3; w.load.y_second = 64'd4;
        pending_words.push_back(w);
        w.mode = 1'b1; pending_words.push_back(w);
        w = '1; w.mode = 1'b0; pending_words.push_back(w);
        w.mode = 1'b1; pending_words.push_back(w);
        drain();

        // Extreme register settings on a close pair.
        write_reg(tbes_pkg::CFG_GM_FIRST, tbes_pkg::MAX63);
        write_reg(tbes_pkg::CFG_GM_SECOND, tbes_pkg::MAX63);
        write_reg(tbes_pkg::CFG_STEP, tbes_pkg::MAX63);
        write_reg(tbes_pkg::CFG_STOP, tbes_pkg::MAX63);
        w = '0; w.load.x_first = 64'd1000; pending_words.push_back(w);
        w.mode = 1'b1; pending_words.push_back(w); pending_words.push_back(w);
        drain();
        write_reg(tbes_pkg::CFG_GM_FIRST, '0);
        write_reg(tbes_pkg::CFG_GM_SECOND, '0);
        write_reg(tbes_pkg::CFG_STEP, '0);
        write_reg(tbes_pkg::CFG_STOP, '0);
        w = '0; w.load.x_first = UNIT64; pending_words.push_back(w);
        w.mode = 1'b1; pending_words.push_back(w);
        drain();

        // Random phases with different settings and handshake pressure.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            write_reg(tbes_pkg::CFG_GM_FIRST,
                      63'($urandom_range(1, 1 << 20)) << $urandom_range(40));
            write_reg(tbes_pkg::CFG_GM_SECOND, (ph == 7) ? tbes_pkg::MAX63 :
                      63'({$urandom, $urandom}) >> $urandom_range(62));
            write_reg(tbes_pkg::CFG_STEP, 63'(UNIT64) >> $urandom_range(8));
            write_reg(tbes_pkg::CFG_STOP, 63'({$urandom, $urandom}) >> $urandom_range(62));
            for (int i = 0; i < 250; i++) begin
                // Mostly load followed by a run of steps on moderate coordinates.
                if (i % 10 == 0)
                    pending_words.push_back(make_load($urandom_range(20)));
                else if ($urandom_range(19) == 0)
                    pending_words.push_back(make_step());
                else begin
                    w = '0; w.mode = 1'b1; pending_words.push_back(w);
                end
            end
            drain();
        end

        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
